[sv/spb_pkg.sv]
// spb_pkg: shared constants, operation and status codes, and the
// controller/datapath command and status structs of the sorted priority buffer.
// No dependencies.
`default_nettype none

package spb_pkg;

  localparam int DEPTH  = 16;
  localparam int DATA_W = 32;
  localparam int POS_W  = 6;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_PEEK   = 2'd1,
    FUNC_DRAIN  = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic load_in;     // capture the input beat
    logic exec;        // carry out the captured operation
    logic drain_step;  // emit the front entry and shift left
  } spb_cmd_t;

  // datapath -> controller
  typedef struct packed {
    func_t func;       // captured operation
    logic  empty;      // no entries stored
    logic  last_one;   // exactly one entry stored
    logic  out_free;   // output register can take a beat this cycle
  } spb_stat_t;

endpackage

`default_nettype wire

[sv/spb_ctrl.sv]
// spb_ctrl: one-hot controller of the sorted priority buffer.
// Depends on spb_pkg (command/status structs, operation codes).
`default_nettype none

module spb_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  spb_pkg::spb_stat_t  stat,
  output spb_pkg::spb_cmd_t   cmd
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_EXEC  = 3'b010,
    S_DRAIN = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    cmd            = '0;
    in_stall       = 1'b1;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.out_free) begin
          cmd.exec = 1'b1;
          if (stat.func == spb_pkg::FUNC_DRAIN && !stat.empty) begin
            state_next = S_DRAIN;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_DRAIN: begin
        if (stat.out_free) begin
          cmd.drain_step = 1'b1;
          if (stat.last_one) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[sv/spb_datapath.sv]
// spb_datapath: input register, sorted entry row with parallel compare and shift,
// entry count and the output register. Depends on spb_pkg.
`default_nettype none

module spb_datapath (
  input  logic                      clk,
  input  logic                      rst,
  input  spb_pkg::spb_cmd_t         cmd,
  output spb_pkg::spb_stat_t        stat,
  input  logic [1:0]                func,
  input  logic signed [31:0]        entry_value,
  input  logic signed [31:0]        entry_priority,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [1:0]                status,
  output logic [5:0]                position,
  output logic signed [31:0]        out_value,
  output logic signed [31:0]        out_priority,
  output logic                      last
);

  localparam int Depth = spb_pkg::DEPTH;
  localparam int IdxW  = spb_pkg::IDX_W;
  localparam int CntW  = spb_pkg::CNT_W;
  localparam int PosW  = spb_pkg::POS_W;

  spb_pkg::func_t            func_q;
  logic signed [31:0]        val_q;
  logic signed [31:0]        pri_q;

  logic signed [31:0]        ent_val [Depth];
  logic signed [31:0]        ent_pri [Depth];
  logic signed [31:0]        ins_val [Depth];
  logic signed [31:0]        ins_pri [Depth];
  logic [CntW-1:0]           count;
  logic [IdxW-1:0]           drain_pos;

  logic [Depth-1:0]          ge;     // stored entry stays ahead of the new one
  logic [IdxW-1:0]           slot;
  logic                      full;
  logic                      empty;
  logic                      last_one;
  logic                      do_insert;
  logic                      out_load;

  // input capture
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      func_q <= spb_pkg::func_t'(func);
      val_q  <= entry_value;
      pri_q  <= entry_priority;
    end
  end

  assign full     = (count == CntW'(Depth));
  assign empty    = (count == '0);
  assign last_one = (count == CntW'(1));

  // ge is a run of ones from the front since entries are sorted
  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      ge[i] = (CntW'(i) < count) && !(ent_pri[i] < pri_q);
    end
  end

  // insert point: first entry that does not stay ahead
  always_comb begin
    slot = '0;
    for (int i = Depth - 1; i >= 0; i--) begin
      if (!ge[i]) begin
        slot = IdxW'(i);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      if (ge[i]) begin
        ins_val[i] = ent_val[i];
        ins_pri[i] = ent_pri[i];
      end else if (i == 0) begin
        ins_val[i] = val_q;
        ins_pri[i] = pri_q;
      end else if (ge[i-1]) begin
        ins_val[i] = val_q;
        ins_pri[i] = pri_q;
      end else begin
        ins_val[i] = ent_val[i-1];
        ins_pri[i] = ent_pri[i-1];
      end
    end
  end

  assign do_insert = cmd.exec && (func_q == spb_pkg::FUNC_INSERT) && !full;

  always_ff @(posedge clk) begin
    if (do_insert) begin
      for (int i = 0; i < Depth; i++) begin
        ent_val[i] <= ins_val[i];
        ent_pri[i] <= ins_pri[i];
      end
    end else if (cmd.drain_step) begin
      for (int i = 0; i < Depth - 1; i++) begin
        ent_val[i] <= ent_val[i+1];
        ent_pri[i] <= ent_pri[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (do_insert) begin
      count <= count + CntW'(1);
    end else if (cmd.drain_step) begin
      count <= count - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      drain_pos <= '0;
    end else if (cmd.drain_step) begin
      drain_pos <= drain_pos + IdxW'(1);
    end
  end

  // output register
  assign out_load = cmd.drain_step
                  || (cmd.exec && (func_q == spb_pkg::FUNC_INSERT
                                   || func_q == spb_pkg::FUNC_PEEK
                                   || (func_q == spb_pkg::FUNC_DRAIN && empty)));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.drain_step) begin
      status       <= spb_pkg::STAT_OK;
      position     <= PosW'(drain_pos);
      out_value    <= ent_val[0];
      out_priority <= ent_pri[0];
      last         <= last_one;
    end else if (out_load) begin
      last <= 1'b1;
      case (func_q)
        spb_pkg::FUNC_INSERT: begin
          out_value    <= val_q;
          out_priority <= pri_q;
          if (full) begin
            status   <= spb_pkg::STAT_FULL;
            position <= '0;
          end else begin
            status   <= spb_pkg::STAT_OK;
            position <= PosW'(slot);
          end
        end
        spb_pkg::FUNC_PEEK: begin
          position <= '0;
          if (empty) begin
            status       <= spb_pkg::STAT_EMPTY;
            out_value    <= '0;
            out_priority <= '0;
          end else begin
            status       <= spb_pkg::STAT_OK;
            out_value    <= ent_val[0];
            out_priority <= ent_pri[0];
          end
        end
        default: begin
          // drain of an empty buffer
          status       <= spb_pkg::STAT_EMPTY;
          position     <= '0;
          out_value    <= '0;
          out_priority <= '0;
        end
      endcase
    end
  end

  assign stat.func     = func_q;
  assign stat.empty    = empty;
  assign stat.last_one = last_one;
  assign stat.out_free = !out_valid || !out_stall;

endmodule

`default_nettype wire

[sv/sorted_priority_buffer_unit.sv]
// sorted_priority_buffer_unit: top level of the sorted priority buffer.
// Depends on spb_pkg, spb_ctrl and spb_datapath.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+-------------------------------------------
//   in      | to block  | in_valid / in_stall | func, entry_value, entry_priority
//   out     | from block| out_valid/out_stall | status, position, out_value, out_priority,
//           |           |                     | last
//
// Steps: insert and peek capture the beat, then compare/shift/emit; a drain of n
//   entries captures, executes, then gives one output beat per cycle unless out_stall
//   holds it, from the front of the entry row, which shifts left after each beat.
// One operation is in flight at a time; in_stall is low only while the controller idles.
// Reset (rst, synchronous) empties the buffer and drops any pending output beat;
//   entry contents are not cleared, the count alone marks what is valid.
// A result held by out_stall sits in the output register; a new input beat is still
//   taken, and its execution waits until the output register frees up.
`default_nettype none

module sorted_priority_buffer_unit (
  input  logic                clk,
  input  logic                rst,
  // input channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          func,
  input  logic signed [31:0]  entry_value,
  input  logic signed [31:0]  entry_priority,
  // output channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          status,
  output logic [5:0]          position,
  output logic signed [31:0]  out_value,
  output logic signed [31:0]  out_priority,
  output logic                last
);

  spb_pkg::spb_cmd_t   cmd;
  spb_pkg::spb_stat_t  stat;

  // sequencing: capture, execute, and per-entry drain steps
  spb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // entry row, parallel priority compare, count and output register
  spb_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .func           (func),
    .entry_value    (entry_value),
    .entry_priority (entry_priority),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .position       (position),
    .out_value      (out_value),
    .out_priority   (out_priority),
    .last           (last)
  );

endmodule

`default_nettype wire

[sv/spb_checker.sv]
// spb_checker: port-level assertions for sorted_priority_buffer_unit, bound to it.
// Depends on spb_pkg (status codes).
`default_nettype none

module spb_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input logic [1:0]          status,
  input logic [5:0]          position,
  input logic signed [31:0]  out_value,
  input logic signed [31:0]  out_priority,
  input logic                last
);

  // a stalled output beat stays
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("output beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(status) && $stable(position)
                               && $stable(out_value) && $stable(out_priority)
                               && $stable(last))
    else $error("stalled output payload changed");

  // one operation at a time: a taken input beat closes the input side
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken twice in a row");

  // empty and full results are single beats at position zero
  a_err_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == spb_pkg::STAT_EMPTY || status == spb_pkg::STAT_FULL)
      |-> last && position == '0)
    else $error("error status without last or with nonzero position");

  // only the defined status codes appear
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == spb_pkg::STAT_OK || status == spb_pkg::STAT_EMPTY
                   || status == spb_pkg::STAT_FULL))
    else $error("undefined status code");

endmodule

bind sorted_priority_buffer_unit spb_checker u_spb_checker (.*);

`default_nettype wire

[test/tb_sorted_priority_buffer_unit.sv]
// Testbench for sorted_priority_buffer_unit: it checks inserts, peeks and drains
// against a predictor of the sorted buffer, with bursty input and a stalling receiver.
// Depends on spb_pkg and the sorted_priority_buffer_unit RTL.
`timescale 1ns / 100ps

module tb_sorted_priority_buffer_unit;

  localparam int RUN_LIMIT    = 400000;  // cycles
  localparam int RANDOM_BEATS = 295;
  localparam int TAIL_CYCLES  = spb_pkg::DEPTH + 24;
  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  // One input beat as queued for the driver.
  typedef struct {
    spb_pkg::func_t     fn;
    logic signed [31:0] value;
    logic signed [31:0] prio;
  } op_beat_t;

  // One output beat the block owes us.
  typedef struct {
    spb_pkg::status_t   st;
    logic [5:0]         pos;
    logic signed [31:0] value;
    logic signed [31:0] prio;
    logic               tail;
  } result_beat_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic [1:0] func;
  logic signed [31:0] entry_value;
  logic signed [31:0] entry_priority;
  logic out_valid;
  logic out_stall;
  logic [1:0] status;
  logic [5:0] position;
  logic signed [31:0] out_value;
  logic signed [31:0] out_priority;
  logic last;

  sorted_priority_buffer_unit dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .func           (func),
    .entry_value    (entry_value),
    .entry_priority (entry_priority),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .position       (position),
    .out_value      (out_value),
    .out_priority   (out_priority),
    .last           (last)
  );

  // Predictor state: the sorted row and its fill level.
  logic signed [31:0] sorted_value [spb_pkg::DEPTH];
  logic signed [31:0] sorted_prio  [spb_pkg::DEPTH];
  int                 fill_level;

  op_beat_t     op_backlog  [$];   // beats still to be driven
  result_beat_t results_due [$];   // beats the block still owes, oldest first

  op_beat_t cur_beat;
  int burst_left, gap_left;
  int stall_mode, stall_span;
  int cycle_count;
  int err_count, beats_sent, beats_checked, drains_seen, refusals_seen;

  // ---------------------------------------------------------------------------
  // Predictor: applies one accepted beat to the row and queues what it causes.
  // ---------------------------------------------------------------------------
  task automatic owe(input spb_pkg::status_t st, input int pos,
                     input logic signed [31:0] v, input logic signed [31:0] p,
                     input logic tail);
    result_beat_t r;
    r.st    = st;
    r.pos   = pos[5:0];
    r.value = v;
    r.prio  = p;
    r.tail  = tail;
    results_due = {results_due, r};
  endtask

  task automatic sort_in_beat(input op_beat_t b);
    int slot;
    case (b.fn)
      spb_pkg::FUNC_INSERT: begin
        if (fill_level >= spb_pkg::DEPTH) begin
          owe(spb_pkg::STAT_FULL, 0, b.value, b.prio, 1'b1);
          refusals_seen++;
        end else begin
          // goes ahead of the first strictly lower priority, so ties keep arrival order
          slot = fill_level;
          for (int i = 0; i < fill_level; i++) begin
            if (sorted_prio[i] < b.prio) begin
              slot = i;
              break;
            end
          end
          for (int i = fill_level; i > slot; i--) begin
            sorted_value[i] = sorted_value[i-1];
            sorted_prio[i]  = sorted_prio[i-1];
          end
          sorted_value[slot] = b.value;
          sorted_prio[slot]  = b.prio;
          fill_level++;
          owe(spb_pkg::STAT_OK, slot, b.value, b.prio, 1'b1);
        end
      end
      spb_pkg::FUNC_PEEK: begin
        if (fill_level == 0) owe(spb_pkg::STAT_EMPTY, 0, 0, 0, 1'b1);
        else owe(spb_pkg::STAT_OK, 0, sorted_value[0], sorted_prio[0], 1'b1);
      end
      spb_pkg::FUNC_DRAIN: begin
        drains_seen++;
        if (fill_level == 0) owe(spb_pkg::STAT_EMPTY, 0, 0, 0, 1'b1);
        else begin
          for (int i = 0; i < fill_level; i++)
            owe(spb_pkg::STAT_OK, i, sorted_value[i], sorted_prio[i],
                i == fill_level - 1);
          fill_level = 0;
        end
      end
      default: ;  // unused code: no beat, no change
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_op(input spb_pkg::func_t fn, input logic signed [31:0] v,
                          input logic signed [31:0] p);
    op_beat_t b;
    b.fn    = fn;
    b.value = v;
    b.prio  = p;
    op_backlog = {op_backlog, b};
  endtask

  // Half the picks from a narrow band so ties are common, plus the extremes and full range.
  function automatic logic signed [31:0] pick_prio();
    int roll;
    roll = $urandom_range(0, 19);
    if (roll < 10) return $urandom_range(0, 5) - 2;
    if (roll < 13) return ($urandom_range(0, 1) == 1) ? S32_MAX : S32_MIN;
    return $signed($urandom);
  endfunction

  // ---------------------------------------------------------------------------
  // Clock and reset
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // ---------------------------------------------------------------------------
  // Driver: bursts of beats from op_backlog with random gaps; a stalled beat
  // is held unchanged. Prediction happens at the edge that accepts the beat.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        sort_in_beat(cur_beat);
        if (cur_beat.fn != spb_pkg::FUNC_NONE) beats_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (op_backlog.size() > 0) begin
          cur_beat = op_backlog.pop_front();
          func           <= cur_beat.fn;
          entry_value    <= cur_beat.value;
          entry_priority <= cur_beat.prio;
          in_valid       <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 12);
            // a quarter of bursts run straight on with no gap
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver stall: a mode is held for a random span, from never stalling
  // through random stalls to a fixed 5-of-8 duty pattern.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_span == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_span = $urandom_range(20, 120);
      end else begin
        stall_span--;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 2) == 0);
        2: out_stall <= ($urandom_range(0, 1) == 1);
        default: out_stall <= ((stall_span % 8) < 5);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every accepted output beat is matched against the oldest owed one.
  // ---------------------------------------------------------------------------
  task automatic flag_error(input string msg);
    err_count++;
    if (err_count <= 10) $display("[%0t] ERROR: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin
    result_beat_t want;
    if (!rst && out_valid && !out_stall) begin
      if (results_due.size() == 0) begin
        flag_error($sformatf("unexpected beat st=%0d pos=%0d val=%0d pri=%0d last=%0b",
                             status, position, out_value, out_priority, last));
      end else begin
        want = results_due.pop_front();
        beats_checked++;
        if (status !== want.st || position !== want.pos || out_value !== want.value ||
            out_priority !== want.prio || last !== want.tail)
          flag_error($sformatf({"beat mismatch: exp st=%0d pos=%0d val=%0d pri=%0d ",
                                "last=%0b, got st=%0d pos=%0d val=%0d pri=%0d last=%0b"},
                               want.st, want.pos, want.value, want.prio, want.tail,
                               status, position, out_value, out_priority, last));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int made, fill_guess, target;
    in_valid       = 1'b0;
    out_stall      = 1'b0;
    func           = spb_pkg::FUNC_NONE;
    entry_value    = '0;
    entry_priority = '0;
    fill_level = 0;
    burst_left = 1;
    gap_left = 0;
    stall_mode = 0;
    stall_span = 0;
    cycle_count = 0;
    err_count = 0;
    beats_sent = 0;
    beats_checked = 0;
    drains_seen = 0;
    refusals_seen = 0;

    // Directed: peek and drain on an empty buffer, the unused code, then a fill
    // with extreme values and priorities and ties at both ends, an insert into a
    // full buffer, and peek / drain / peek to see it empty again.
    queue_op(spb_pkg::FUNC_PEEK, 0, 0);
    queue_op(spb_pkg::FUNC_DRAIN, 0, 0);
    queue_op(spb_pkg::FUNC_NONE, -1, -1);
    queue_op(spb_pkg::FUNC_INSERT, S32_MAX, 0);
    queue_op(spb_pkg::FUNC_INSERT, S32_MIN, 0);
    queue_op(spb_pkg::FUNC_INSERT, 1, S32_MAX);
    queue_op(spb_pkg::FUNC_INSERT, -1, S32_MIN);
    queue_op(spb_pkg::FUNC_INSERT, 5, S32_MAX);
    queue_op(spb_pkg::FUNC_INSERT, 6, S32_MIN);
    for (int i = 0; i < 10; i++) queue_op(spb_pkg::FUNC_INSERT, 100 + i, (i % 3) - 1);
    queue_op(spb_pkg::FUNC_INSERT, 32'sh5555_5555, 32'sh2AAA_AAAA);
    queue_op(spb_pkg::FUNC_PEEK, 0, 0);
    queue_op(spb_pkg::FUNC_DRAIN, 0, 0);
    queue_op(spb_pkg::FUNC_PEEK, 0, 0);

    // Random: fill-and-drain rounds with peeks mixed in; about one round in five
    // fills to the top or past it, so refusals show up.
    made = 0;
    fill_guess = 0;
    while (made < RANDOM_BEATS) begin
      target = ($urandom_range(0, 4) == 0) ? spb_pkg::DEPTH + $urandom_range(0, 3)
                                           : $urandom_range(0, 12);
      while (fill_guess < target) begin
        case ($urandom_range(0, 19)) inside
          0: queue_op(spb_pkg::FUNC_NONE, $signed($urandom), $signed($urandom));
          [1:3]: begin
            queue_op(spb_pkg::FUNC_PEEK, $signed($urandom), $signed($urandom));
            made++;
          end
          default: begin
            queue_op(spb_pkg::FUNC_INSERT, $signed($urandom), pick_prio());
            fill_guess++;
            made++;
          end
        endcase
      end
      queue_op(spb_pkg::FUNC_DRAIN, $signed($urandom), $signed($urandom));
      fill_guess = 0;
      made++;
    end

    @(negedge rst);
    while ((op_backlog.size() > 0 || in_valid || results_due.size() > 0) &&
           cycle_count < RUN_LIMIT)
      @(posedge clk);

    if (cycle_count >= RUN_LIMIT) begin
      $display("Timeout after %0d cycles, %0d beats still owed", cycle_count,
               results_due.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      // let a late or spurious beat show up before closing
      repeat (TAIL_CYCLES) @(posedge clk);
      if (results_due.size() > 0) begin
        err_count += results_due.size();
        $display("ERROR: %0d expected beats never arrived", results_due.size());
      end
      $display("Sent %0d operations (%0d drains, %0d full refusals), checked %0d beats,",
               beats_sent, drains_seen, refusals_seen, beats_checked);
      $display("in %0d cycles; %0d errors counted", cycle_count, err_count);
      if (err_count == 0)
        $display("Testbench completed without errors");
      else
        $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

endmodule

[files.f]
sv/spb_pkg.sv
sv/spb_ctrl.sv
sv/spb_datapath.sv
sv/sorted_priority_buffer_unit.sv
sv/spb_checker.sv
test/tb_sorted_priority_buffer_unit.sv
